>>> src/oiq_pkg.sv
// ----------------------------------------------------------------------------
// Ordered insert queue package
// Shared widths, operation and status codes, and the command and status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package oiq_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_PUSH   = 3'd0;
    localparam op_t OP_INSERT = 3'd1;
    localparam op_t OP_POP    = 3'd2;
    localparam op_t OP_ERASE  = 3'd3;
    localparam op_t OP_GET    = 3'd4;
    localparam op_t OP_CLEAR  = 3'd5;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK       = 3'd0;
    localparam status_t ST_FULL     = 3'd1;
    localparam status_t ST_EMPTY    = 3'd2;
    localparam status_t ST_NOTFOUND = 3'd3;
    localparam status_t ST_RANGE    = 3'd4;

    typedef logic [3:0] act_t;

    localparam act_t ACT_NONE       = 4'd0;
    localparam act_t ACT_PUSH       = 4'd1;
    localparam act_t ACT_CLEAR      = 4'd2;
    localparam act_t ACT_SCAN_START = 4'd3;
    localparam act_t ACT_GET_READ   = 4'd4;
    localparam act_t ACT_INS_STEP   = 4'd5;
    localparam act_t ACT_POP_STEP   = 4'd6;
    localparam act_t ACT_ERS_STEP   = 4'd7;
    localparam act_t ACT_INS_TAIL   = 4'd8;

    typedef struct packed {
        logic    load;
        act_t    act;
        logic    res_set;
        status_t res_status;
        logic    res_data;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic pos_bad;
        logic first;
        logic last;
        logic found_any;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> src/oiq_ctrl.sv
// ----------------------------------------------------------------------------
// Ordered insert queue controller
// Sequences each operation through dispatch and, as it needs, the entry
// walk, the tail write or the get read wait, and then the report state.
// ----------------------------------------------------------------------------
`default_nettype none

module oiq_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [oiq_pkg::OP_W-1:0]  operation,
    input  oiq_pkg::dp_stat_t         dstat,
    output logic                      busy,
    output logic                      done,
    output oiq_pkg::cmd_t             cmd
);
    import oiq_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_TAIL     = 3'd3;
    localparam logic [2:0] S_GET_WAIT = 3'd4;
    localparam logic [2:0] S_REPORT   = 3'd5;

    logic [2:0] state_reg, state_next;
    op_t        op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_PUSH;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    op_next    = operation;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next  = S_REPORT;
                cmd.res_set = 1'b1;
                cmd.res_status = ST_OK;
                case (op_reg)
                    OP_PUSH:
                    begin
                        if (dstat.full)
                            cmd.res_status = ST_FULL;
                        else
                            cmd.act = ACT_PUSH;
                    end
                    OP_INSERT:
                    begin
                        if (dstat.full)
                            cmd.res_status = ST_FULL;
                        else
                        begin
                            cmd.res_set = 1'b0;
                            cmd.act     = ACT_SCAN_START;
                            state_next  = dstat.empty ? S_TAIL : S_SCAN;
                        end
                    end
                    OP_POP:
                    begin
                        if (dstat.empty)
                            cmd.res_status = ST_EMPTY;
                        else
                        begin
                            cmd.res_set = 1'b0;
                            cmd.act     = ACT_SCAN_START;
                            state_next  = S_SCAN;
                        end
                    end
                    OP_ERASE:
                    begin
                        if (dstat.empty)
                            cmd.res_status = ST_NOTFOUND;
                        else
                        begin
                            cmd.res_set = 1'b0;
                            cmd.act     = ACT_SCAN_START;
                            state_next  = S_SCAN;
                        end
                    end
                    OP_GET:
                    begin
                        if (dstat.empty)
                            cmd.res_status = ST_EMPTY;
                        else if (dstat.pos_bad)
                            cmd.res_status = ST_RANGE;
                        else
                        begin
                            cmd.res_set = 1'b0;
                            cmd.act     = ACT_GET_READ;
                            state_next  = S_GET_WAIT;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cmd.act = ACT_CLEAR;
                    end
                    default:
                    begin
                        cmd.act = ACT_NONE;
                    end
                endcase
            end
            S_SCAN:
            begin
                case (op_reg)
                    OP_INSERT:
                    begin
                        cmd.act = ACT_INS_STEP;
                        if (dstat.last)
                            state_next = S_TAIL;
                    end
                    OP_POP:
                    begin
                        cmd.act = ACT_POP_STEP;
                        // The head is on the read port during the first step.
                        if (dstat.first)
                        begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = ST_OK;
                            cmd.res_data   = 1'b1;
                        end
                        if (dstat.last)
                            state_next = S_REPORT;
                    end
                    OP_ERASE:
                    begin
                        cmd.act = ACT_ERS_STEP;
                        if (dstat.last)
                        begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = dstat.found_any ? ST_OK : ST_NOTFOUND;
                            state_next     = S_REPORT;
                        end
                    end
                    default:
                    begin
                        state_next = S_REPORT;
                    end
                endcase
            end
            S_TAIL:
            begin
                cmd.act        = ACT_INS_TAIL;
                cmd.res_set    = 1'b1;
                cmd.res_status = ST_OK;
                state_next     = S_REPORT;
            end
            S_GET_WAIT:
            begin
                cmd.res_set    = 1'b1;
                cmd.res_status = ST_OK;
                cmd.res_data   = 1'b1;
                state_next     = S_REPORT;
            end
            S_REPORT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_REPORT);

endmodule

`default_nettype wire

>>> src/oiq_datapath.sv
// ----------------------------------------------------------------------------
// Ordered insert queue datapath
// Entry memory with one write and one registered read port, entry count,
// walk pointers and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module oiq_datapath #(
    parameter int CAPACITY   = oiq_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = oiq_pkg::DATA_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  oiq_pkg::cmd_t                 cmd,
    input  logic [oiq_pkg::VALUE_W-1:0]   value,
    input  logic [oiq_pkg::POS_W-1:0]     position,
    output oiq_pkg::dp_stat_t             dstat,
    output logic [oiq_pkg::VALUE_W-1:0]   read_value,
    output logic [oiq_pkg::STATUS_W-1:0]  status,
    output logic [oiq_pkg::COUNT_W-1:0]   count
);
    import oiq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef logic [DATA_WIDTH-1:0] data_t;

    data_t mem [CAPACITY];

    data_t                value_reg;
    logic [POS_W-1:0]     pos_reg;
    data_t                carry_reg, carry_next;
    data_t                rd_data_reg;
    logic [CW-1:0]        count_reg, count_next;
    logic [AW-1:0]        elem_reg, elem_next;
    logic [CW-1:0]        wptr_reg, wptr_next;
    logic                 placed_reg, placed_next;
    logic                 found_reg, found_next;
    logic [VALUE_W-1:0]   read_value_reg;
    status_t              status_reg;

    logic [63:0]          value_ext;
    logic [63:0]          rd_ext;
    logic                 gt, ge, match, first, last, place_here;
    logic                 we;
    logic [AW-1:0]        waddr, raddr;
    data_t                wdata;

    assign value_ext = 64'($signed(value));
    assign rd_ext    = 64'($signed(rd_data_reg));

    assign gt         = $signed(value_reg) >  $signed(rd_data_reg);
    assign ge         = $signed(value_reg) >= $signed(rd_data_reg);
    assign match      = (value_reg == rd_data_reg);
    assign first      = (elem_reg == '0);
    assign last       = ((CW'(elem_reg) + CW'(1)) == count_reg);
    // The head takes the new value only if strictly smaller; later entries
    // are passed while they stay strictly greater.
    assign place_here = !placed_reg && (first ? gt : ge);

    assign dstat.full      = (count_reg == CAP_C);
    assign dstat.empty     = (count_reg == '0);
    assign dstat.pos_bad   = (PW'(pos_reg) >= PW'(count_reg));
    assign dstat.first     = first;
    assign dstat.last      = last;
    assign dstat.found_any = found_reg | match;

    always_comb
    begin
        we    = 1'b0;
        waddr = elem_reg;
        wdata = rd_data_reg;
        case (cmd.act)
            ACT_PUSH:
            begin
                we    = 1'b1;
                waddr = count_reg[AW-1:0];
                wdata = value_reg;
            end
            ACT_INS_STEP:
            begin
                if (placed_reg)
                begin
                    we    = 1'b1;
                    wdata = carry_reg;
                end
                else if (place_here)
                begin
                    we    = 1'b1;
                    wdata = value_reg;
                end
            end
            ACT_POP_STEP:
            begin
                we    = !first;
                waddr = elem_reg - AW'(1);
            end
            ACT_ERS_STEP:
            begin
                we    = !match;
                waddr = wptr_reg[AW-1:0];
            end
            ACT_INS_TAIL:
            begin
                we    = 1'b1;
                waddr = count_reg[AW-1:0];
                wdata = placed_reg ? carry_reg : value_reg;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.act)
            ACT_SCAN_START: raddr = '0;
            ACT_GET_READ:   raddr = AW'(pos_reg);
            default:        raddr = elem_reg + AW'(1);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_data_reg <= mem[raddr];
    end

    always_comb
    begin
        count_next  = count_reg;
        elem_next   = elem_reg;
        wptr_next   = wptr_reg;
        placed_next = placed_reg;
        found_next  = found_reg;
        carry_next  = carry_reg;
        case (cmd.act)
            ACT_PUSH:
            begin
                count_next = count_reg + CW'(1);
            end
            ACT_CLEAR:
            begin
                count_next = '0;
            end
            ACT_SCAN_START:
            begin
                elem_next   = '0;
                wptr_next   = '0;
                placed_next = 1'b0;
                found_next  = 1'b0;
            end
            ACT_INS_STEP:
            begin
                elem_next = elem_reg + AW'(1);
                if (placed_reg || place_here)
                begin
                    carry_next  = rd_data_reg;
                    placed_next = 1'b1;
                end
            end
            ACT_POP_STEP:
            begin
                elem_next = elem_reg + AW'(1);
                if (last)
                    count_next = count_reg - CW'(1);
            end
            ACT_ERS_STEP:
            begin
                elem_next = elem_reg + AW'(1);
                if (match)
                    found_next = 1'b1;
                else
                    wptr_next = wptr_reg + CW'(1);
                if (last)
                    count_next = wptr_reg + CW'(!match);
            end
            ACT_INS_TAIL:
            begin
                count_next = count_reg + CW'(1);
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            elem_reg   <= '0;
            wptr_reg   <= '0;
            placed_reg <= 1'b0;
            found_reg  <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            count_reg  <= count_next;
            elem_reg   <= elem_next;
            wptr_reg   <= wptr_next;
            placed_reg <= placed_next;
            found_reg  <= found_next;
            if (cmd.res_set)
                status_reg <= cmd.res_status;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
        if (cmd.load)
        begin
            value_reg <= value_ext[DATA_WIDTH-1:0];
            pos_reg   <= position;
        end
        if (cmd.res_set)
        begin
            if (cmd.res_status != ST_OK)
                read_value_reg <= '1;
            else if (cmd.res_data)
                read_value_reg <= rd_ext[VALUE_W-1:0];
            else
                read_value_reg <= '0;
        end
    end

    assign read_value = read_value_reg;
    assign status     = status_reg;
    assign count      = COUNT_W'(count_reg);

endmodule

`default_nettype wire

>>> src/ordered_insert_queue_unit.sv
// ----------------------------------------------------------------------------
// Ordered insert queue unit
// Bounded ordered list of signed values with push, ordered insert, pop,
// erase, get and clear; one result per transaction.
//
// Channel   Handshake                Payload
// command   start, busy              operation, value, position
// result    done (one-cycle strobe)  read_value, status, count
//
// A command is taken when start is high and busy is low; busy then stays
// high until the cycle after done. Push, clear and rejected commands go
// from dispatch straight to the result; a get that reads an entry waits
// for the memory read port first. Pop and erase walk the stored entries
// through the single memory read port, one entry a cycle. Ordered insert
// walks and shifts the same way and adds a tail write. After reset the
// list is empty; the result cannot be held off by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_insert_queue_unit #(
    parameter int CAPACITY   = oiq_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = oiq_pkg::DATA_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [oiq_pkg::OP_W-1:0]      operation,
    input  logic [oiq_pkg::VALUE_W-1:0]   value,
    input  logic [oiq_pkg::POS_W-1:0]     position,
    output logic                          done,
    output logic [oiq_pkg::VALUE_W-1:0]   read_value,
    output logic [oiq_pkg::STATUS_W-1:0]  status,
    output logic [oiq_pkg::COUNT_W-1:0]   count
);
    import oiq_pkg::*;

    cmd_t     cmd;
    dp_stat_t dstat;

    oiq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .dstat     (dstat),
        .busy      (busy),
        .done      (done),
        .cmd       (cmd)
    );

    oiq_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .value      (value),
        .position   (position),
        .dstat      (dstat),
        .read_value (read_value),
        .status     (status),
        .count      (count)
    );

    // A result is a single-cycle strobe.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe lasted more than one cycle");

    // The unit is free again right after reporting.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !busy)
        else $error("busy held after result");

    // A full status leaves the list at capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (count == COUNT_W'(CAPACITY)))
        else $error("full status with list below capacity");

    // Any failure status returns all ones as data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (read_value == '1))
        else $error("failure status without all-ones data");

endmodule

`default_nettype wire

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// Ordered insert queue unit testbench
// Sends directed and random commands through the start/busy handshake and
// checks every done strobe against a fixed expectation or a local model of
// the ordered list. Random traffic mixes single operations with runs of
// pushes and inserts that drive the list to full. The sender idles at a
// different rate in each of three phases.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import oiq_pkg::*;

    localparam op_t         OP_SPARE6    = 3'd6;
    localparam op_t         OP_SPARE7    = 3'd7;
    localparam logic [31:0] NO_VALUE     = 32'hFFFF_FFFF;
    localparam int          LIST_DEPTH   = 64;
    localparam int          RANDOM_ITEMS = 500;
    localparam int          DRAIN_CYCLES = 80;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DIRECTED_N   = 25;

    typedef struct packed {
        logic [31:0]  read_val;
        status_t      stat;
        logic [6:0]   entries;
    } outcome_t;

    typedef struct {
        op_t          op;
        logic [31:0]  val;
        logic [5:0]   pos;
        bit           typed;
        outcome_t     known;
    } step_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [OP_W-1:0]     operation;
    logic [VALUE_W-1:0]  value;
    logic [POS_W-1:0]    position;
    logic                done;
    logic [VALUE_W-1:0]  read_value;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;

    logic signed [31:0]  held_entries[$];
    outcome_t            pending_results[$];
    step_t               directed_steps[DIRECTED_N];
    int                  mismatches;
    int                  cycles;

    ordered_insert_queue_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .value      (value),
        .position   (position),
        .done       (done),
        .read_value (read_value),
        .status     (status),
        .count      (count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Applies one operation to the local list and returns what the unit
    // should answer.
    function automatic outcome_t apply_to_list(input op_t op, input logic [31:0] val,
                                               input logic [5:0] pos);
        outcome_t           res;
        logic signed [31:0] v;
        logic signed [31:0] kept[$];
        int                 i;
        v = val;
        res.read_val = 32'd0;
        res.stat = ST_OK;
        case (op)
            OP_PUSH:
            begin
                if (held_entries.size() >= LIST_DEPTH)
                    res.stat = ST_FULL;
                else
                    held_entries.push_back(v);
            end
            OP_INSERT:
            begin
                if (held_entries.size() >= LIST_DEPTH)
                    res.stat = ST_FULL;
                else if (held_entries.size() == 0 || v > held_entries[0])
                    held_entries.push_front(v);
                else
                begin
                    // The walk past the head stops at the first entry that is not strictly
                    // greater, so equal values land in front of older equals but behind an equal head.
                    i = 0;
                    while (i + 1 < held_entries.size() && v < held_entries[i + 1])
                        i++;
                    held_entries.insert(i + 1, v);
                end
            end
            OP_POP:
            begin
                if (held_entries.size() == 0)
                    res.stat = ST_EMPTY;
                else
                    res.read_val = held_entries.pop_front();
            end
            OP_ERASE:
            begin
                foreach (held_entries[k])
                    if (held_entries[k] != v)
                        kept.push_back(held_entries[k]);
                if (kept.size() == held_entries.size())
                    res.stat = ST_NOTFOUND;
                held_entries = kept;
            end
            OP_GET:
            begin
                if (held_entries.size() == 0)
                    res.stat = ST_EMPTY;
                else if (int'(pos) >= held_entries.size())
                    res.stat = ST_RANGE;
                else
                    res.read_val = held_entries[pos];
            end
            OP_CLEAR:
                held_entries.delete();
            default:
                ;
        endcase
        if (res.stat != ST_OK)
            res.read_val = NO_VALUE;
        res.entries = 7'(held_entries.size());
        return res;
    endfunction

    // One command transaction; the expectation is recorded at the accepting edge.
    task automatic issue(input op_t op, input logic [31:0] val, input logic [5:0] pos,
                         input int idle_pct, input bit typed, input outcome_t known);
        outcome_t predicted;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start     <= 1'b1;
        operation <= op;
        value     <= val;
        position  <= pos;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = apply_to_list(op, val, pos);
        pending_results.push_back(typed ? known : predicted);
        @(negedge clk);
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [31:0] draw_value();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return 32'($urandom_range(16)) - 32'd8;
            5:
            begin
                case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return NO_VALUE;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic run_random(input int n_items, input int idle_pct);
        int          sent;
        int          fill_left;
        int          pick;
        op_t         op;
        logic [31:0] val;
        logic [5:0]  pos;
        sent = 0;
        fill_left = 0;
        while (sent < n_items)
        begin
            val = draw_value();
            pos = 6'($urandom_range(63));
            if (fill_left > 0)
            begin
                op = $urandom_range(1) ? OP_PUSH : OP_INSERT;
                fill_left--;
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 26)
                    op = OP_PUSH;
                else if (pick < 52)
                    op = OP_INSERT;
                else if (pick < 66)
                    op = OP_POP;
                else if (pick < 77)
                    op = OP_ERASE;
                else if (pick < 91)
                    op = OP_GET;
                else if (pick < 94)
                    op = OP_CLEAR;
                else if (pick < 97)
                    op = $urandom_range(1) ? OP_SPARE6 : OP_SPARE7;
                else
                begin
                    // Run the list up to full and a few commands past it.
                    fill_left = LIST_DEPTH - held_entries.size() + $urandom_range(1, 4);
                    continue;
                end
            end
            if (op == OP_ERASE && held_entries.size() != 0 && $urandom_range(1))
                val = held_entries[$urandom_range(held_entries.size() - 1)];
            if (op == OP_GET && held_entries.size() != 0 && $urandom_range(1))
                pos = 6'($urandom_range(held_entries.size() - 1));
            issue(op, val, pos, idle_pct, 1'b0, '0);
            sent++;
        end
    endtask

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result strobe with no command outstanding");
            else
            begin
                want = pending_results.pop_front();
                if (read_value !== want.read_val)
                    report_mismatch($sformatf("read_value %h, model %h",
                                              read_value, want.read_val));
                if (status !== want.stat)
                    report_mismatch($sformatf("status %0d, model %0d",
                                              status, want.stat));
                if (count !== want.entries)
                    report_mismatch($sformatf("count %0d, model %0d",
                                              count, want.entries));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        mismatches = 0;
        cycles     = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        operation  = OP_PUSH;
        value      = 32'd0;
        position   = 6'd0;

        directed_steps = '{
            '{OP_POP,    32'd0,        6'd0,  1'b1, '{NO_VALUE, ST_EMPTY, 7'd0}},
            '{OP_GET,    32'd0,        6'd0,  1'b1, '{NO_VALUE, ST_EMPTY, 7'd0}},
            '{OP_ERASE,  32'd5,        6'd0,  1'b1, '{NO_VALUE, ST_NOTFOUND, 7'd0}},
            '{OP_SPARE6, 32'd0,        6'd0,  1'b1, '{32'd0, ST_OK, 7'd0}},
            '{OP_SPARE7, NO_VALUE,     6'd63, 1'b1, '{32'd0, ST_OK, 7'd0}},
            '{OP_PUSH,   32'h7FFFFFFF, 6'd0,  1'b1, '{32'd0, ST_OK, 7'd1}},
            '{OP_PUSH,   32'h80000000, 6'd0,  1'b1, '{32'd0, ST_OK, 7'd2}},
            '{OP_GET,    32'd0,        6'd1,  1'b1, '{32'h80000000, ST_OK, 7'd2}},
            '{OP_GET,    32'd0,        6'd63, 1'b1, '{NO_VALUE, ST_RANGE, 7'd2}},
            '{OP_GET,    32'd0,        6'd2,  1'b1, '{NO_VALUE, ST_RANGE, 7'd2}},
            '{OP_INSERT, 32'd5,        6'd0,  1'b0, '0},
            '{OP_INSERT, 32'h7FFFFFFF, 6'd0,  1'b0, '0},
            '{OP_INSERT, NO_VALUE,     6'd0,  1'b0, '0},
            '{OP_INSERT, 32'h80000000, 6'd0,  1'b0, '0},
            '{OP_PUSH,   32'd5,        6'd0,  1'b0, '0},
            '{OP_ERASE,  32'd5,        6'd0,  1'b0, '0},
            '{OP_ERASE,  32'd12345,    6'd0,  1'b0, '0},
            '{OP_POP,    32'd0,        6'd0,  1'b0, '0},
            '{OP_GET,    32'd0,        6'd0,  1'b0, '0},
            '{OP_CLEAR,  32'hAAAAAAAA, 6'd42, 1'b1, '{32'd0, ST_OK, 7'd0}},
            '{OP_INSERT, 32'hFFFFFFF0, 6'd0,  1'b1, '{32'd0, ST_OK, 7'd1}},
            '{OP_INSERT, 32'd3,        6'd0,  1'b0, '0},
            '{OP_POP,    32'd0,        6'd0,  1'b0, '0},
            '{OP_ERASE,  32'hFFFFFFF0, 6'd0,  1'b0, '0},
            '{OP_PUSH,   32'h55555555, 6'd21, 1'b0, '0}
        };

        repeat (9)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_steps[i])
            issue(directed_steps[i].op, directed_steps[i].val, directed_steps[i].pos,
                  12, directed_steps[i].typed, directed_steps[i].known);
        wait_all_results();

        run_random(RANDOM_ITEMS / 3, 12);
        wait_all_results();
        run_random(RANDOM_ITEMS / 3, 68);
        wait_all_results();
        run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3), 0);
        wait_all_results();

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
